### hdl/stl_pkg.sv
// Shared types, token codes and keyword table for the source token lexer.
// Used by stl_core, stl_fifo and source_token_lexer; depends on nothing.
package stl_pkg;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CHAR = 2'd1;
	localparam logic [1:0] ERR_STR  = 2'd2;

	localparam logic [5:0] T_LPAREN    = 6'd0;
	localparam logic [5:0] T_RPAREN    = 6'd1;
	localparam logic [5:0] T_LBRACE    = 6'd2;
	localparam logic [5:0] T_RBRACE    = 6'd3;
	localparam logic [5:0] T_COMMA     = 6'd4;
	localparam logic [5:0] T_DOT       = 6'd5;
	localparam logic [5:0] T_MINUS     = 6'd6;
	localparam logic [5:0] T_PLUS      = 6'd7;
	localparam logic [5:0] T_SEMI      = 6'd8;
	localparam logic [5:0] T_SLASH     = 6'd9;
	localparam logic [5:0] T_STAR      = 6'd10;
	localparam logic [5:0] T_BANG      = 6'd11;
	localparam logic [5:0] T_EQUAL     = 6'd13;
	localparam logic [5:0] T_GREATER   = 6'd15;
	localparam logic [5:0] T_LESS      = 6'd17;
	localparam logic [5:0] T_IDENT     = 6'd19;
	localparam logic [5:0] T_STRING    = 6'd20;
	localparam logic [5:0] T_NUMBER    = 6'd21;
	localparam logic [5:0] T_KW0       = 6'd22;
	localparam logic [5:0] T_ERROR     = 6'd40;
	localparam logic [5:0] T_EOF       = 6'd41;

	localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
	localparam logic [23:0] LINE_INIT = 24'd1;

	localparam int NUM_KW   = 18;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int MAX_RES  = 3;

	// Keywords left-justified in 48 bits, first character in the top byte.
	localparam logic [47:0] KW_WORD [NUM_KW] = '{
		{"and", 24'h0}, {"class", 8'h0}, {"def", 24'h0}, {"else", 16'h0},
		{"false", 8'h0}, {"for", 24'h0}, {"fun", 24'h0}, {"if", 32'h0},
		{"let", 24'h0}, {"nil", 24'h0}, {"or", 32'h0}, {"print", 8'h0},
		{"return"}, {"super", 8'h0}, {"this", 16'h0}, {"true", 16'h0},
		{"var", 24'h0}, {"while", 8'h0}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd3, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd3, 3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
	};

	typedef struct packed {
		logic [5:0]  token_type;
		logic [1:0]  error_kind;
		logic [23:0] token_start;
		logic [23:0] token_length;
		logic [23:0] line_number;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0]           n;
		tok_t [MAX_RES-1:0]   tok;
	} res_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	// Single-character token for ( ) { } , . - + ; *, or T_ERROR for any other byte.
	function automatic logic [5:0] single_tok(input logic [7:0] c);
		logic [5:0] t;
		case (c)
			"(":     t = T_LPAREN;
			")":     t = T_RPAREN;
			"{":     t = T_LBRACE;
			"}":     t = T_RBRACE;
			",":     t = T_COMMA;
			".":     t = T_DOT;
			"-":     t = T_MINUS;
			"+":     t = T_PLUS;
			";":     t = T_SEMI;
			"*":     t = T_STAR;
			default: t = T_ERROR;
		endcase
		return t;
	endfunction

	// len is 2..6; pre holds the identifier's first bytes, first in the top byte.
	function automatic logic [5:0] ident_code(input logic [2:0] len, input logic [47:0] pre);
		logic [5:0]  code;
		logic [47:0] mask;
		code = T_IDENT;
		mask = ~(48'hFFFF_FFFF_FFFF >> (6'(len) * 6'd8));
		for (int k = 0; k < NUM_KW; k++) begin
			if ((len == KW_LEN[k]) && ((pre & mask) == KW_WORD[k]))
				code = T_KW0 + 6'(k);
		end
		return code;
	endfunction

	function automatic tok_t make_tok(input logic [5:0] ty, input logic [1:0] err,
			input logic [23:0] start, input logic [23:0] len, input logic [23:0] line);
		tok_t t;
		t.token_type   = ty;
		t.error_kind   = err;
		t.token_start  = start;
		t.token_length = len;
		t.line_number  = line;
		t.last         = 1'b0;
		return t;
	endfunction

endpackage

### hdl/source_token_lexer.sv
// Streaming lexer top level: input register, scanner step, result queue.
// An accepted beat is scanned from the input register once the queue has room.
// Throughput: one byte per cycle while each byte yields at most one token and
// results are taken each cycle; a byte that yields two or three tokens holds the
// input until the four-entry result queue has room for three.
// Reset: idle mode, offset 0, line 1, queue empty. Uses stl_pkg, stl_core, stl_fifo.
module source_token_lexer #(
	parameter int POS_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_type,
	output logic [1:0]  error_kind,
	output logic [23:0] token_start,
	output logic [23:0] token_length,
	output logic [23:0] line_number,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data
);
	import stl_pkg::*;

	logic           s1_valid_q;
	logic           op_s1;
	logic [7:0]     ch_s1;
	logic           room, step, accept, pop;
	logic [RQ_AW:0] q_count;
	res_t           res;
	tok_t           head;
	logic [1:0]     push_n;

	// Process only when the queue can take a full three-token burst.
	assign room     = q_count <= (RQ_AW+1)'(RQ_DEPTH - MAX_RES);
	assign step     = s1_valid_q && room;
	assign in_stall = s1_valid_q && !room;
	assign accept   = in_valid && !in_stall;
	assign push_n   = step ? res.n : 2'd0;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (step) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			ch_s1 <= char_byte;
		end
	end

	stl_core #(
		.POS_WIDTH(POS_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.op       (op_s1),
		.ch       (ch_s1),
		.cfg_we   (cfg_wr_en),
		.cfg_data (cfg_wr_data),
		.res      (res)
	);

	stl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_tok (res.tok),
		.pop      (pop),
		.head     (head),
		.count    (q_count)
	);

	assign out_valid    = (q_count != '0);
	assign token_type   = head.token_type;
	assign error_kind   = head.error_kind;
	assign token_start  = head.token_start;
	assign token_length = head.token_length;
	assign line_number  = head.line_number;
	assign last         = head.last;

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> s1_valid_q)
		else $error("held beat dropped from input register");

endmodule

### hdl/stl_core.sv
// Scanner state and the per-byte step logic: mode, offsets, line count and
// identifier prefix. Produces up to three tokens per step. Uses stl_pkg.
module stl_core #(
	parameter int POS_WIDTH = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           op,
	input  logic [7:0]     ch,
	input  logic           cfg_we,
	input  logic [23:0]    cfg_data,
	output stl_pkg::res_t  res
);
	import stl_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
		M_NUM, M_NUMDOT, M_NUMFRAC, M_IDENT, M_STR
	} mode_t;

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	mode_t                mode_q, mode_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d, org_q, org_d;
	logic [23:0]          line_q, line_d, line_inc;
	logic [7:0]           prefix_q [6];
	logic                 pref_we;
	logic [2:0]           pref_idx;

	logic [POS_WIDTH-1:0] span_p, span_p1, span_pm1, pos_m1;
	logic [5:0]           id_type, pend_type;
	logic                 id_range;

	logic                 do_idle;
	logic                 c_ws, c_nl, c_dig, c_alp, c_alnum;
	mode_t                ic_mode;
	logic [5:0]           ic_type;
	logic [1:0]           n;
	tok_t [MAX_RES-1:0]   toks;

	assign span_p   = pos_q - org_q;
	assign span_p1  = pos_q + 1'b1 - org_q;
	assign pos_m1   = pos_q - 1'b1;
	assign span_pm1 = pos_m1 - org_q;
	assign line_inc = (line_q != LINE_MAX) ? line_q + 24'd1 : line_q;

	assign id_range = (span_p >= POS_WIDTH'(2)) && (span_p <= POS_WIDTH'(6));
	assign id_type  = id_range ? ident_code(span_p[2:0], {prefix_q[0], prefix_q[1],
		prefix_q[2], prefix_q[3], prefix_q[4], prefix_q[5]}) : T_IDENT;

	always_comb begin
		case (mode_q)
			M_BANG:    pend_type = T_BANG;
			M_EQUAL:   pend_type = T_EQUAL;
			M_GREATER: pend_type = T_GREATER;
			default:   pend_type = T_LESS;
		endcase
	end

	// Character classes and the between-tokens decision.
	assign c_ws    = (ch == " ") || (ch == 8'h0D) || (ch == 8'h09);
	assign c_nl    = (ch == 8'h0A);
	assign c_dig   = is_dig(ch);
	assign c_alp   = is_alp(ch);
	assign c_alnum = c_dig || c_alp;
	assign ic_type = single_tok(ch);

	always_comb begin
		if (c_dig) begin
			ic_mode = M_NUM;
		end else if (c_alp) begin
			ic_mode = M_IDENT;
		end else begin
			case (ch)
				"!":     ic_mode = M_BANG;
				"=":     ic_mode = M_EQUAL;
				"<":     ic_mode = M_LESS;
				">":     ic_mode = M_GREATER;
				"/":     ic_mode = M_SLASH;
				8'h22:   ic_mode = M_STR;
				default: ic_mode = M_IDLE;
			endcase
		end
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		org_d    = org_q;
		line_d   = line_q;
		pref_we  = 1'b0;
		pref_idx = span_p[2:0];
		do_idle  = 1'b0;
		n        = 2'd0;
		toks     = '0;

		if (op == OP_EOF) begin
			case (mode_q)
				M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
					toks[n] = make_tok(pend_type, ERR_NONE, 24'(org_q), 24'd1, line_q);
					n = n + 2'd1;
				end
				M_SLASH: begin
					toks[n] = make_tok(T_SLASH, ERR_NONE, 24'(org_q), 24'd1, line_q);
					n = n + 2'd1;
				end
				M_NUM, M_NUMFRAC: begin
					toks[n] = make_tok(T_NUMBER, ERR_NONE, 24'(org_q), 24'(span_p), line_q);
					n = n + 2'd1;
				end
				M_NUMDOT: begin
					toks[n] = make_tok(T_NUMBER, ERR_NONE, 24'(org_q), 24'(span_pm1), line_q);
					n = n + 2'd1;
					toks[n] = make_tok(T_DOT, ERR_NONE, 24'(pos_m1), 24'd1, line_q);
					n = n + 2'd1;
				end
				M_IDENT: begin
					toks[n] = make_tok(id_type, ERR_NONE, 24'(org_q), 24'(span_p), line_q);
					n = n + 2'd1;
				end
				M_STR: begin
					toks[n] = make_tok(T_ERROR, ERR_STR, 24'(org_q), 24'(span_p), line_q);
					n = n + 2'd1;
				end
				default: ;
			endcase
			toks[n] = make_tok(T_EOF, ERR_NONE, 24'(pos_q), 24'd0, line_q);
			n = n + 2'd1;
			mode_d = M_IDLE;
		end else begin
			case (mode_q)
				M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
					if (ch == "=") begin
						toks[n] = make_tok(pend_type + 6'd1, ERR_NONE, 24'(org_q),
							24'(span_p1), line_q);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						toks[n] = make_tok(pend_type, ERR_NONE, 24'(org_q), 24'd1, line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_SLASH: begin
					if (ch == "/") begin
						mode_d = M_COMMENT;
					end else begin
						toks[n] = make_tok(T_SLASH, ERR_NONE, 24'(org_q), 24'd1, line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c_nl) begin
						line_d = line_inc;
						mode_d = M_IDLE;
					end
				end
				M_NUM: begin
					if (ch == ".") begin
						mode_d = M_NUMDOT;
					end else if (!c_dig) begin
						toks[n] = make_tok(T_NUMBER, ERR_NONE, 24'(org_q), 24'(span_p), line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (c_dig) begin
						mode_d = M_NUMFRAC;
					end else begin
						toks[n] = make_tok(T_NUMBER, ERR_NONE, 24'(org_q), 24'(span_pm1), line_q);
						n = n + 2'd1;
						toks[n] = make_tok(T_DOT, ERR_NONE, 24'(pos_m1), 24'd1, line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_NUMFRAC: begin
					if (!c_dig) begin
						toks[n] = make_tok(T_NUMBER, ERR_NONE, 24'(org_q), 24'(span_p), line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (c_alnum) begin
						pref_we = (span_p < POS_WIDTH'(6));
					end else begin
						toks[n] = make_tok(id_type, ERR_NONE, 24'(org_q), 24'(span_p), line_q);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				M_STR: begin
					if (ch == 8'h22) begin
						toks[n] = make_tok(T_STRING, ERR_NONE, 24'(org_q), 24'(span_p1), line_q);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else if (c_nl) begin
						line_d = line_inc;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// Byte handled as between tokens.
			if (do_idle) begin
				mode_d = M_IDLE;
				if (c_nl) begin
					line_d = line_inc;
				end else if (!c_ws) begin
					org_d  = pos_q;
					mode_d = ic_mode;
					if (c_alp) begin
						pref_we  = 1'b1;
						pref_idx = 3'd0;
					end
					if (ic_mode == M_IDLE) begin
						toks[n] = make_tok(ic_type, (ic_type == T_ERROR) ? ERR_CHAR : ERR_NONE,
							24'(pos_q), 24'd1, line_q);
						n = n + 2'd1;
					end
				end
			end

			if (pos_q != POS_MAX)
				pos_d = pos_q + 1'b1;
		end

		for (int i = 0; i < MAX_RES; i++)
			toks[i].last = (2'(i) == n - 2'd1);
	end

	assign res.n   = n;
	assign res.tok = toks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			org_q  <= '0;
			line_q <= LINE_INIT;
		end else if (cfg_we) begin
			line_q <= cfg_data;
		end else if (step) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			org_q  <= org_d;
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && (op == OP_CHAR) && pref_we)
			prefix_q[pref_idx] <= ch;
	end

	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (op == OP_EOF)) |-> (res.n != 2'd0))
		else $error("end of input produced no token");

endmodule

### hdl/stl_fifo.sv
// Result queue: takes up to three tokens per cycle, hands out one per beat.
// Uses stl_pkg for the token type and depth.
module stl_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       push_n,
	input  stl_pkg::tok_t [stl_pkg::MAX_RES-1:0] push_tok,
	input  logic                             pop,
	output stl_pkg::tok_t                    head,
	output logic [stl_pkg::RQ_AW:0]          count
);
	import stl_pkg::*;

	tok_t             mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [RQ_AW:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push_n)
				mem_q[wr_ptr_q + RQ_AW'(i)] <= push_tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			count_q  <= count_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> ((count_q + (RQ_AW+1)'(push_n)) <= (RQ_AW+1)'(RQ_DEPTH)))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("result queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("result queue count out of range");

endmodule

### bench/source_token_lexer_tb.sv
// Self-checking bench for source_token_lexer: random source text, a scanner predictor and
// a result scoreboard, with bursty input, receiver stalls and first-line register changes.
// Depends on stl_pkg for token codes and the result struct; needs only the RTL.
module source_token_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stl_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX = 10;
	localparam int HOLD_CYCLES = 120;

	typedef enum logic [3:0] {
		SC_IDLE, SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER, SC_SLASH, SC_COMMENT,
		SC_NUM, SC_NUMDOT, SC_NUMFRAC, SC_IDENT, SC_STR
	} scan_e;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} src_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        op = OP_CHAR;
	logic [7:0]  char_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = 24'd0;
	logic        in_stall;
	logic        out_valid;
	logic [5:0]  token_type;
	logic [1:0]  error_kind;
	logic [23:0] token_start;
	logic [23:0] token_length;
	logic [23:0] line_number;
	logic        tok_last;

	source_token_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.char_byte(char_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_type(token_type),
		.error_kind(error_kind),
		.token_start(token_start),
		.token_length(token_length),
		.line_number(line_number),
		.last(tok_last),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	string kw_names [NUM_KW] = '{"and", "class", "def", "else", "false", "for", "fun", "if",
		"let", "nil", "or", "print", "return", "super", "this", "true", "var", "while"};
	string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string word_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string punct_chars = "(){},.-+;*";
	string bad_chars = "@#$%&^~\\|?:[]'";
	string space_chars = " \t\r\n";

	// scanner state as the block should hold it
	scan_e       sc_mode;
	logic [23:0] sc_pos;
	logic [23:0] sc_origin;
	logic [23:0] sc_line;
	logic [7:0]  sc_prefix [6];

	tok_t        step_toks [$];
	tok_t        expected_tokens [$];
	src_beat_t   src_beats [$];
	int          phase_beats;
	int          err_count = 0;
	int          tokens_seen = 0;
	int          cycles = 0;
	int          tick = 0;
	int          hold_left = 0;
	int          gap_left = 0;
	int          burst_left = 8;

	function automatic logic is_digit_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_ch(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [5:0] punct_code(input logic [7:0] c);
		case (c)
			"(": return T_LPAREN;
			")": return T_RPAREN;
			"{": return T_LBRACE;
			"}": return T_RBRACE;
			",": return T_COMMA;
			".": return T_DOT;
			"-": return T_MINUS;
			"+": return T_PLUS;
			";": return T_SEMI;
			"*": return T_STAR;
			default: return T_ERROR;
		endcase
	endfunction

	function automatic logic [5:0] pending_code(input scan_e m);
		case (m)
			SC_BANG: return T_BANG;
			SC_EQUAL: return T_EQUAL;
			SC_GREATER: return T_GREATER;
			default: return T_LESS;
		endcase
	endfunction

	function automatic logic [5:0] ident_kind(input logic [23:0] len);
		int k, i;
		logic hit;
		if (len < 2 || len > 6)
			return T_IDENT;
		for (k = 0; k < NUM_KW; k++) begin
			if (kw_names[k].len() == len) begin
				hit = 1'b1;
				for (i = 0; i < len; i++)
					if (kw_names[k][i] != sc_prefix[i])
						hit = 1'b0;
				if (hit)
					return T_KW0 + 6'(k);
			end
		end
		return T_IDENT;
	endfunction

	task automatic add_tok(input logic [5:0] ty, input logic [1:0] err,
			input logic [23:0] start, input logic [23:0] len);
		tok_t t;
		t.token_type = ty;
		t.error_kind = err;
		t.token_start = start;
		t.token_length = len;
		t.line_number = sc_line;
		t.last = 1'b0;
		if (step_toks.size() < MAX_RES)
			step_toks.push_back(t);
	endtask

	task automatic bump_line();
		if (sc_line != LINE_MAX)
			sc_line = sc_line + 24'd1;
	endtask

	// byte seen between tokens
	task automatic scan_idle(input logic [7:0] c, input logic [23:0] p);
		logic [5:0] pc;
		sc_mode = SC_IDLE;
		if (c == " " || c == 8'h0d || c == 8'h09)
			return;
		if (c == 8'h0a) begin
			bump_line();
			return;
		end
		sc_origin = p;
		if (is_digit_ch(c)) begin
			sc_mode = SC_NUM;
		end else if (is_word_ch(c)) begin
			sc_prefix[0] = c;
			sc_mode = SC_IDENT;
		end else begin
			case (c)
				"!": sc_mode = SC_BANG;
				"=": sc_mode = SC_EQUAL;
				"<": sc_mode = SC_LESS;
				">": sc_mode = SC_GREATER;
				"/": sc_mode = SC_SLASH;
				"\"": sc_mode = SC_STR;
				default: begin
					pc = punct_code(c);
					add_tok(pc, (pc == T_ERROR) ? ERR_CHAR : ERR_NONE, p, 24'd1);
				end
			endcase
		end
	endtask

	// advance the scanner by one accepted beat and queue the tokens it completes
	task automatic scan_byte(input logic op_i, input logic [7:0] c);
		logic [23:0] p;
		tok_t t;
		int i;
		p = sc_pos;
		step_toks.delete();
		if (op_i == OP_EOF) begin
			case (sc_mode)
				SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER:
					add_tok(pending_code(sc_mode), ERR_NONE, sc_origin, 24'd1);
				SC_SLASH: add_tok(T_SLASH, ERR_NONE, sc_origin, 24'd1);
				SC_NUM, SC_NUMFRAC: add_tok(T_NUMBER, ERR_NONE, sc_origin, p - sc_origin);
				SC_NUMDOT: begin
					add_tok(T_NUMBER, ERR_NONE, sc_origin, p - 24'd1 - sc_origin);
					add_tok(T_DOT, ERR_NONE, p - 24'd1, 24'd1);
				end
				SC_IDENT: add_tok(ident_kind(p - sc_origin), ERR_NONE, sc_origin, p - sc_origin);
				SC_STR: add_tok(T_ERROR, ERR_STR, sc_origin, p - sc_origin);
				default: ;
			endcase
			add_tok(T_EOF, ERR_NONE, p, 24'd0);
			sc_mode = SC_IDLE;
		end else begin
			case (sc_mode)
				SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER: begin
					if (c == "=") begin
						add_tok(pending_code(sc_mode) + 6'd1, ERR_NONE, sc_origin,
							p + 24'd1 - sc_origin);
						sc_mode = SC_IDLE;
					end else begin
						add_tok(pending_code(sc_mode), ERR_NONE, sc_origin, 24'd1);
						scan_idle(c, p);
					end
				end
				SC_SLASH: begin
					if (c == "/") begin
						sc_mode = SC_COMMENT;
					end else begin
						add_tok(T_SLASH, ERR_NONE, sc_origin, 24'd1);
						scan_idle(c, p);
					end
				end
				SC_COMMENT: begin
					if (c == 8'h0a) begin
						bump_line();
						sc_mode = SC_IDLE;
					end
				end
				SC_NUM: begin
					if (c == ".") begin
						sc_mode = SC_NUMDOT;
					end else if (!is_digit_ch(c)) begin
						add_tok(T_NUMBER, ERR_NONE, sc_origin, p - sc_origin);
						scan_idle(c, p);
					end
				end
				SC_NUMDOT: begin
					if (is_digit_ch(c)) begin
						sc_mode = SC_NUMFRAC;
					end else begin
						add_tok(T_NUMBER, ERR_NONE, sc_origin, p - 24'd1 - sc_origin);
						add_tok(T_DOT, ERR_NONE, p - 24'd1, 24'd1);
						scan_idle(c, p);
					end
				end
				SC_NUMFRAC: begin
					if (!is_digit_ch(c)) begin
						add_tok(T_NUMBER, ERR_NONE, sc_origin, p - sc_origin);
						scan_idle(c, p);
					end
				end
				SC_IDENT: begin
					if (is_word_ch(c) || is_digit_ch(c)) begin
						if (p - sc_origin < 6)
							sc_prefix[3'(p - sc_origin)] = c;
					end else begin
						add_tok(ident_kind(p - sc_origin), ERR_NONE, sc_origin, p - sc_origin);
						scan_idle(c, p);
					end
				end
				SC_STR: begin
					if (c == "\"") begin
						add_tok(T_STRING, ERR_NONE, sc_origin, p + 24'd1 - sc_origin);
						sc_mode = SC_IDLE;
					end else if (c == 8'h0a) begin
						bump_line();
					end
				end
				default: scan_idle(c, p);
			endcase
			if (sc_pos != 24'hFFFFFF)
				sc_pos = sc_pos + 24'd1;
		end
		for (i = 0; i < step_toks.size(); i++) begin
			t = step_toks[i];
			t.last = (i == step_toks.size() - 1);
			expected_tokens.push_back(t);
		end
	endtask

	// sender: bursts of random length with random gaps; hold a stalled beat
	always @(posedge clk) begin : drive_src
		logic held, send;
		src_beat_t nxt;
		held = in_valid && in_stall;
		send = held;
		nxt.op = op;
		nxt.ch = char_byte;
		if (in_valid && !in_stall)
			scan_byte(op, char_byte);
		if (arst_n && !held) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (src_beats.size() > 0) begin
				nxt = src_beats.pop_front();
				send = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				nxt.op = 1'($urandom_range(0, 1));
				nxt.ch = 8'($urandom_range(0, 255));
			end
		end
		in_valid <= send;
		op <= nxt.op;
		char_byte <= nxt.ch;
	end

	// receiver: check each token, stall on a rotating pattern plus long hold-offs
	always @(posedge clk) begin : take_tokens
		tok_t want;
		logic stall_nx;
		if (arst_n) begin
			tick++;
			if (out_valid && !out_stall) begin
				tokens_seen++;
				if (expected_tokens.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("unexpected token: type %0d err %0d start %0d len %0d line %0d",
							token_type, error_kind, token_start, token_length, line_number);
				end else begin
					want = expected_tokens.pop_front();
					if (token_type !== want.token_type || error_kind !== want.error_kind ||
							token_start !== want.token_start ||
							token_length !== want.token_length ||
							line_number !== want.line_number || tok_last !== want.last) begin
						err_count++;
						if (err_count <= REPORT_MAX) begin
							$display("mismatch, want type %0d err %0d start %0d len %0d line %0d last %0d",
								want.token_type, want.error_kind, want.token_start,
								want.token_length, want.line_number, want.last);
							$display("           got type %0d err %0d start %0d len %0d line %0d last %0d",
								token_type, error_kind, token_start, token_length,
								line_number, tok_last);
						end
					end
				end
				if (tokens_seen == 30 || tokens_seen == 150)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_nx = 1'b1;
			end else begin
				case ((tick / 160) % 4)
					0: stall_nx = 1'b0;
					1: stall_nx = ($urandom_range(0, 3) == 0);
					2: stall_nx = ($urandom_range(0, 3) != 0);
					default: stall_nx = ((tick % 5) < 2);
				endcase
			end
			out_stall <= stall_nx;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic put_char(input logic [7:0] c);
		src_beat_t b;
		b.op = OP_CHAR;
		b.ch = c;
		src_beats.push_back(b);
		phase_beats++;
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_eof();
		src_beat_t b;
		b.op = OP_EOF;
		b.ch = 8'($urandom_range(0, 255));
		src_beats.push_back(b);
		phase_beats++;
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// one well-formed lexeme with random content, or now and then noise
	task automatic add_lexeme();
		int sel, n, i;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			put_text(kw_names[$urandom_range(0, NUM_KW - 1)]);
			if ($urandom_range(0, 4) == 0)
				put_char(pick(word_body));
		end else if (sel < 24) begin
			n = $urandom_range(1, 9);
			put_char(pick(word_head));
			for (i = 1; i < n; i++)
				put_char(pick(word_body));
		end else if (sel < 36) begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				put_char("0" + 8'($urandom_range(0, 9)));
			case ($urandom_range(0, 2))
				0: ;
				1: begin
					put_char(".");
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++)
						put_char("0" + 8'($urandom_range(0, 9)));
				end
				default: put_char(".");
			endcase
		end else if (sel < 46) begin
			put_char("\"");
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++) begin
				c = ($urandom_range(0, 5) == 0) ? 8'h0a : 8'($urandom_range(0, 255));
				put_char((c == "\"") ? 8'h27 : c);
			end
			if ($urandom_range(0, 6) != 0)
				put_char("\"");
			else
				put_eof();
		end else if (sel < 58) begin
			put_char(pick("!=<>/"));
			if ($urandom_range(0, 1) == 0)
				put_char("=");
		end else if (sel < 64) begin
			put_text("//");
			n = $urandom_range(0, 5);
			for (i = 0; i < n; i++) begin
				c = 8'($urandom_range(0, 255));
				put_char((c == 8'h0a) ? "x" : c);
			end
			put_char(8'h0a);
		end else if (sel < 76) begin
			put_char(pick(punct_chars));
		end else if (sel < 82) begin
			case ($urandom_range(0, 2))
				0: put_char(pick(bad_chars));
				1: put_char(8'($urandom_range(128, 255)));
				default: put_char(8'($urandom_range(0, 8)));
			endcase
		end else if (sel < 90) begin
			put_char(pick(space_chars));
		end else if (sel < 97) begin
			put_char(8'($urandom_range(0, 255)));
		end else begin
			put_eof();
		end
		if ($urandom_range(0, 1) == 0)
			put_char(pick(space_chars));
	endtask

	task automatic random_phase(input int n);
		phase_beats = 0;
		while (phase_beats < n)
			add_lexeme();
		put_eof();
	endtask

	// wait until every beat is taken and every token has come back
	task automatic settle();
		while (src_beats.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_first_line(input logic [23:0] v);
		settle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sc_line = v;
	endtask

	initial begin : stimulus
		int i;
		sc_mode = SC_IDLE;
		sc_pos = 24'd0;
		sc_origin = 24'd0;
		sc_line = LINE_INIT;
		for (i = 0; i < 6; i++)
			sc_prefix[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// keyword, two-char op, number with dot before a letter, comment, bad bytes,
		// unterminated string, then bytes after end of input with a pending operator
		put_text("if <=7.e//x\n");
		put_char(8'h00);
		put_char(8'hFF);
		put_text("\"a\n");
		put_eof();
		put_text(">=!");
		put_eof();

		set_first_line(24'd0);
		random_phase(120);
		set_first_line(LINE_MAX);
		random_phase(60);
		set_first_line(LINE_MAX - 24'd1);
		random_phase(60);
		set_first_line(24'($urandom));
		random_phase(110);
		set_first_line(LINE_INIT);
		random_phase(100);
		settle();
		repeat (10) @(posedge clk);

		if (err_count == 0 && expected_tokens.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
